// File: hdl/eet_pkg.sv
// ----------------------------------------------------------------------------
// eet_pkg
// Shared widths, register indexes and reset values for the ellipse tracker.
// ----------------------------------------------------------------------------
package eet_pkg;

  localparam int COORD_BITS = 7;
  localparam int FRAC_BITS  = 16;
  localparam int ST_W       = 24;          // Q8.16 state width
  localparam int NORM_W     = 20;          // Q8.12 normalized offset
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 3;
  localparam int NUM_W      = 41;          // |rotated offset|
  localparam int MUL_W      = 30;          // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [ST_W-1:0] ST_MAX = {ST_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_SEARCH_RADIUS = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPREAD_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_COS_ANGLE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIN_ANGLE     = 3'd5;

  localparam logic [CFG_W-1:0] RST_SEARCH_RADIUS = 16'd6144;
  localparam logic [CFG_W-1:0] RST_CENTER_GAIN   = 16'd328;
  localparam logic [CFG_W-1:0] RST_RADIUS_GAIN   = 16'd33;
  localparam logic [CFG_W-1:0] RST_SPREAD_GAIN   = 16'd8192;
  localparam logic [CFG_W-1:0] RST_COS_ANGLE     = 16'd16384;
  localparam logic [CFG_W-1:0] RST_SIN_ANGLE     = 16'd0;

  localparam logic [ST_W-1:0] RST_TRACK_X = 24'd3670016;   // 56.0
  localparam logic [ST_W-1:0] RST_TRACK_Y = 24'd4587520;   // 70.0
  localparam logic [ST_W-1:0] RST_TRACK_R = 24'd1179648;   // 18.0

endpackage

// File: hdl/event_ellipse_tracker.sv
// ----------------------------------------------------------------------------
// event_ellipse_tracker
// Fixed-point ellipse tracker for an address-event camera.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) takes one event word: column, row and
//    timestamp. in_stall is high while an event is being worked on.
//  - Output channel (out_valid/out_stall) gives one result word per event:
//    inside flag, updated center and radii, normalized offset, timestamp.
//  - Config channel (cfg_valid/cfg_ready) writes one 16-bit register per
//    handshake; cfg_ready is always high. Write only while idle.
//  - One shared 30x30 multiplier and one restoring divider do all the math.
//    A rejected event skips the center and radius updates and goes straight
//    to the result; the two divisions dominate the work (a division that
//    saturates finishes after its overflow check, with no quotient steps).
//    One event at a time: while the receiver keeps up, the next event can be
//    taken in the cycle after the result is registered.
//  - A finished result sits in the output register; a new event may be
//    accepted while it waits, and its own result holds until that is taken.
//  - Reset (rst, synchronous) restores the default registers and the
//    initial ellipse: center (56, 70), radii 18.
// ----------------------------------------------------------------------------
module event_ellipse_tracker (
  input  logic                       clk,
  input  logic                       rst,
  // event in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [6:0]                 event_x,
  input  logic [6:0]                 event_y,
  input  logic [31:0]                event_time,
  // result out
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       inside_res,
  output logic [eet_pkg::ST_W-1:0]   center_x,
  output logic [eet_pkg::ST_W-1:0]   center_y,
  output logic [eet_pkg::ST_W-1:0]   radius_a,
  output logic [eet_pkg::ST_W-1:0]   radius_b,
  output logic signed [eet_pkg::NORM_W-1:0] norm_offset,
  output logic [31:0]                stamp,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [eet_pkg::IDX_W-1:0]  cfg_index,
  input  logic [eet_pkg::CFG_W-1:0]  cfg_data
);
  import eet_pkg::*;

  // sequencer steps
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_U0   = 5'd1;
  localparam logic [4:0] ST_U1   = 5'd2;
  localparam logic [4:0] ST_V0   = 5'd3;
  localparam logic [4:0] ST_V1   = 5'd4;
  localparam logic [4:0] ST_V2   = 5'd5;
  localparam logic [4:0] ST_DA   = 5'd6;
  localparam logic [4:0] ST_DB   = 5'd7;
  localparam logic [4:0] ST_Q0   = 5'd8;
  localparam logic [4:0] ST_Q1   = 5'd9;
  localparam logic [4:0] ST_Q2   = 5'd10;
  localparam logic [4:0] ST_CX0  = 5'd11;
  localparam logic [4:0] ST_CX1  = 5'd12;
  localparam logic [4:0] ST_CY0  = 5'd13;
  localparam logic [4:0] ST_CY1  = 5'd14;
  localparam logic [4:0] ST_G0   = 5'd15;
  localparam logic [4:0] ST_G1   = 5'd16;
  localparam logic [4:0] ST_TA   = 5'd17;
  localparam logic [4:0] ST_FA   = 5'd18;
  localparam logic [4:0] ST_RA   = 5'd19;
  localparam logic [4:0] ST_TB   = 5'd20;
  localparam logic [4:0] ST_FB   = 5'd21;
  localparam logic [4:0] ST_RB   = 5'd22;
  localparam logic [4:0] ST_RB1  = 5'd23;
  localparam logic [4:0] ST_OUT  = 5'd24;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // configuration
  logic [CFG_W-1:0]        search_radius, center_gain, radius_gain, spread_gain;
  logic signed [CFG_W-1:0] cos_angle, sin_angle;

  // tracked ellipse
  logic [ST_W-1:0] track_x, track_y, track_a, track_b;

  logic [4:0]               step;
  logic [ST_W-1:0]          ex, ey;
  logic [31:0]              time_q;
  logic signed [ST_W:0]     dx, dy;
  logic signed [NUM_W-1:0]  u, v;
  logic signed [NORM_W-1:0] xa, yb;
  logic                     in_range;
  logic [ST_W-1:0]          nx, ny, na, nb;
  logic [19:0]              g;
  logic [27:0]              f;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, acc, sum, diff;

  logic                     div_start, div_done, div_neg;
  logic [NUM_W-1:0]         div_num;
  logic [ST_W-1:0]          div_den;
  logic signed [NORM_W-1:0] div_quo;

  logic [NORM_W-2:0]        xa_abs, yb_abs;
  logic [43:0]              hi_sum, hi_prod;
  logic [ST_W-1:0]          csat, rclamp;
  logic [16:0]              alpha_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = (step != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius <= RST_SEARCH_RADIUS;
      center_gain   <= RST_CENTER_GAIN;
      radius_gain   <= RST_RADIUS_GAIN;
      spread_gain   <= RST_SPREAD_GAIN;
      cos_angle     <= RST_COS_ANGLE;
      sin_angle     <= RST_SIN_ANGLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEARCH_RADIUS: search_radius <= cfg_data;
        REG_CENTER_GAIN:   center_gain   <= cfg_data;
        REG_RADIUS_GAIN:   radius_gain   <= cfg_data;
        REG_SPREAD_GAIN:   spread_gain   <= cfg_data;
        REG_COS_ANGLE:     cos_angle     <= cfg_data;
        REG_SIN_ANGLE:     sin_angle     <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared arithmetic helpers
  assign sum     = acc + prod;
  assign diff    = acc - prod;
  assign xa_abs  = xa[NORM_W-1] ? (NORM_W-1)'(-xa) : xa[NORM_W-2:0];
  assign yb_abs  = yb[NORM_W-1] ? (NORM_W-1)'(-yb) : yb[NORM_W-2:0];
  assign hi_sum  = sum[59:16];
  assign hi_prod = prod[59:16];
  assign csat    = (|hi_sum[43:24]) ? ST_MAX : hi_sum[23:0];
  assign rclamp  = (|hi_prod[43:24]) ? ST_MAX :
                   (hi_prod[23:0] == '0) ? ST_W'(1) : hi_prod[23:0];
  assign alpha_c = ONE_Q16 - {1'b0, center_gain};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      ST_U0:  begin mul_a = MUL_W'(dx); mul_b = MUL_W'(cos_angle); end
      ST_U1:  begin mul_a = MUL_W'(dy); mul_b = MUL_W'(sin_angle); end
      ST_V0:  begin mul_a = MUL_W'(dx); mul_b = MUL_W'(sin_angle); end
      ST_V1:  begin mul_a = MUL_W'(dy); mul_b = MUL_W'(cos_angle); end
      ST_Q0:  begin mul_a = MUL_W'(xa); mul_b = MUL_W'(xa); end
      ST_Q1:  begin mul_a = MUL_W'(yb); mul_b = MUL_W'(yb); end
      ST_CX0: begin mul_a = MUL_W'(center_gain); mul_b = MUL_W'(ex); end
      ST_CX1: begin mul_a = MUL_W'(alpha_c); mul_b = MUL_W'(track_x); end
      ST_CY0: begin mul_a = MUL_W'(center_gain); mul_b = MUL_W'(ey); end
      ST_CY1: begin mul_a = MUL_W'(alpha_c); mul_b = MUL_W'(track_y); end
      ST_G0:  begin mul_a = MUL_W'(radius_gain); mul_b = MUL_W'(spread_gain); end
      ST_TA:  begin mul_a = MUL_W'(g); mul_b = MUL_W'(xa_abs); end
      ST_RA:  begin mul_a = MUL_W'(track_a); mul_b = MUL_W'(f); end
      ST_TB:  begin mul_a = MUL_W'(g); mul_b = MUL_W'(yb_abs); end
      ST_RB:  begin mul_a = MUL_W'(track_b); mul_b = MUL_W'(f); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider hookup: |u|/4a first, then |v|/4b
  always_comb begin
    div_start = 1'b0;
    div_num   = u[NUM_W-1] ? NUM_W'(-u) : NUM_W'(u);
    div_neg   = u[NUM_W-1];
    div_den   = track_a;
    if (step == ST_V2) begin
      div_start = 1'b1;
    end else if (step == ST_DA) begin
      div_start = div_done;
      div_num   = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
      div_neg   = v[NUM_W-1];
      div_den   = track_b;
    end
  end

  eet_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .neg   (div_neg),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      out_valid <= 1'b0;
      track_x   <= RST_TRACK_X;
      track_y   <= RST_TRACK_Y;
      track_a   <= RST_TRACK_R;
      track_b   <= RST_TRACK_R;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (step)
        ST_IDLE: if (in_valid) step <= ST_U0;
        ST_DA:   if (div_done) step <= ST_DB;
        ST_DB:   if (div_done) step <= ST_Q0;
        ST_Q2:   step <= (sum <= $signed(PROD_W'({search_radius, 12'b0})))
                         ? ST_CX0 : ST_OUT;
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            step      <= ST_IDLE;
            if (in_range) begin
              track_x <= nx;
              track_y <= ny;
              track_a <= na;
              track_b <= nb;
            end
          end
        end
        default: step <= step + 5'd1;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (step)
      ST_IDLE: begin
        ex     <= {8'(1 << COORD_BITS) - {1'b0, event_y}, FRAC_BITS'(0)};
        ey     <= {1'b0, event_x, FRAC_BITS'(0)};
        dx     <= $signed({1'b0, 8'(1 << COORD_BITS) - {1'b0, event_y}, FRAC_BITS'(0)})
                  - $signed({1'b0, track_x});
        dy     <= $signed({2'b0, event_x, FRAC_BITS'(0)}) - $signed({1'b0, track_y});
        time_q <= event_time;
      end
      ST_U1:  acc <= prod;
      ST_V0:  u   <= sum[NUM_W-1:0];
      ST_V1:  acc <= prod;
      ST_V2:  v   <= diff[NUM_W-1:0];
      ST_DA:  if (div_done) xa <= div_quo;
      ST_DB:  if (div_done) yb <= div_quo;
      ST_Q1:  acc <= prod;
      ST_Q2:  in_range <= (sum <= $signed(PROD_W'({search_radius, 12'b0})));
      ST_CX1: acc <= prod;
      ST_CY0: nx  <= csat;
      ST_CY1: acc <= prod;
      ST_G0:  ny  <= csat;
      ST_G1:  g   <= prod[31:12];
      ST_FA:  f   <= 28'(ONE_Q16) - 28'(radius_gain) + 28'(prod[38:12]);
      ST_TB:  na  <= rclamp;
      ST_FB:  f   <= 28'(ONE_Q16) - 28'(radius_gain) + 28'(prod[38:12]);
      ST_RB1: nb  <= rclamp;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (step == ST_OUT && (!out_valid || !out_stall)) begin
      inside_res  <= in_range;
      center_x    <= in_range ? nx : track_x;
      center_y    <= in_range ? ny : track_y;
      radius_a    <= in_range ? na : track_a;
      radius_b    <= in_range ? nb : track_b;
      norm_offset <= xa;
      stamp       <= time_q;
    end
  end

  // radii are clamped, so the divider never sees zero
  a_radius_nonzero: assert property (@(posedge clk) disable iff (rst)
    track_a != '0 && track_b != '0)
    else $error("tracked radius reached zero");

  // a rejected event leaves the ellipse alone
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !inside_res |-> $stable(track_x) && $stable(track_a))
    else $error("ellipse changed on a rejected event");

  // divider only finishes while the sequencer waits for it
  a_div_done_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (step == ST_DA || step == ST_DB))
    else $error("divider finished outside a wait step");

endmodule

// File: hdl/eet_div.sv
// ----------------------------------------------------------------------------
// eet_div
// Restoring divider: num / (4*den), truncated, saturated to +-(2^19-1).
// ----------------------------------------------------------------------------
module eet_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eet_pkg::NUM_W-1:0]   num,
  input  logic                        neg,
  input  logic [eet_pkg::ST_W-1:0]    den,
  output logic                        done,
  output logic signed [eet_pkg::NORM_W-1:0] quo
);
  import eet_pkg::*;

  localparam int QB = NORM_W - 1;          // magnitude bits
  localparam int DS_W = ST_W + 2 + QB - 1; // divisor aligned to top quotient bit

  logic            busy;
  logic            chk;
  logic [4:0]      cnt;
  logic            sign;
  logic [DS_W-1:0] rem;
  logic [DS_W-1:0] dsor;
  logic [QB-1:0]   q;
  logic            ovf;
  logic            ge;

  assign ovf = {1'b0, rem} >= {dsor, 1'b0};
  assign ge  = rem >= dsor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        chk  <= 1'b1;
      end else if (busy && chk) begin
        chk <= 1'b0;
        if (ovf) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= DS_W'(num);
      dsor <= {den, 2'b00, {(QB-1){1'b0}}};
      sign <= neg;
      q    <= '0;
    end else if (busy && chk) begin
      cnt <= 5'(QB - 1);
      if (ovf) begin
        q <= '1;
      end
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsor;
      end
      q    <= {q[QB-2:0], ge};
      dsor <= dsor >> 1;
      cnt  <= cnt - 5'd1;
    end
  end

  assign quo = sign ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule
